// ----- sv/dltq_pkg.sv -----
package dltq_pkg;

  // Default queue depth
  localparam int DEF_CAPACITY = 16;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TIME   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_POPPED  = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] time_value;
    logic [7:0]  entry_tag;
  } dltq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] popped_tag;
    logic [4:0] entry_count;
  } dltq_out_t;

  // One stored queue entry
  typedef struct packed {
    logic [15:0] delta;
    logic [7:0]  tag;
  } dltq_entry_t;

endpackage

// ----- sv/delta_list_timer_queue.sv -----
// Sequence: an insert walks past the entries that expire at or before it, reduces the entry
//   it stops on and moves the later entries back; time-passed zeroes the covered entries and
//   reduces the one it stops on; a pop checks the head and, if it has expired, moves the rest
//   down. Commands with nothing to do go straight to the result. The steps share one subtractor.
// Throughput: one command at a time; the next is taken the cycle after the result is
//   registered, which waits until the output register is free. Reset: synchronous, active
//   low; clears the count and control, the store is not cleared.
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dltq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output dltq_out_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_FIX     = 4'd3;
  localparam logic [3:0] S_SHR_RD  = 4'd4;
  localparam logic [3:0] S_SHR_WR  = 4'd5;
  localparam logic [3:0] S_PUT     = 4'd6;
  localparam logic [3:0] S_TP_RD   = 4'd7;
  localparam logic [3:0] S_TP_CMP  = 4'd8;
  localparam logic [3:0] S_POP_RD  = 4'd9;
  localparam logic [3:0] S_POP_CHK = 4'd10;
  localparam logic [3:0] S_SHL_RD  = 4'd11;
  localparam logic [3:0] S_SHL_WR  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]       state_r,  state_nxt;
  logic [1:0]       cmd_r,    cmd_nxt;
  logic [15:0]      acc_r,    acc_nxt;
  logic [7:0]       tag_r,    tag_nxt;
  logic [CNT_W-1:0] pos_r,    pos_nxt;
  logic [CNT_W-1:0] k_r,      k_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [7:0]       popped_r, popped_nxt;
  logic             out_valid_r, out_valid_nxt;
  dltq_out_t        out_data_r,  out_data_nxt;

  // Entry memory, one write and one registered read per cycle
  dltq_entry_t      mem [CAPACITY];
  dltq_entry_t      rd_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  dltq_entry_t      mem_wdata;

  // Shared subtractor; operands swap when the remainder goes into the entry
  logic [15:0] op_x, op_y;
  logic [16:0] sub;
  logic [CNT_W-1:0] km1;

  assign op_x = (state_r == S_FIX) ? rd_q.delta : acc_r;
  assign op_y = (state_r == S_FIX) ? acc_r : rd_q.delta;
  assign sub  = {1'b0, op_x} - {1'b0, op_y};
  assign km1  = k_r - ONE_CNT;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    acc_nxt       = acc_r;
    tag_nxt       = tag_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_raddr     = '0;
    mem_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.command;
          acc_nxt    = in_data.time_value;
          tag_nxt    = in_data.entry_tag;
          pos_nxt    = '0;
          popped_nxt = '0;
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
          case (in_data.command)
            CMD_INSERT: begin
              if (count_r == CAP_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            CMD_TIME: begin
              if (in_data.time_value != 16'd0) begin
                state_nxt = S_TP_RD;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_NONE;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Insert: walk past entries that expire at or before the new one
      S_INS_RD: begin
        if (pos_r == count_r) begin
          k_nxt     = count_r;
          state_nxt = S_SHR_RD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_r[IDX_W-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (!sub[16]) begin
          acc_nxt   = sub[15:0];
          pos_nxt   = pos_r + ONE_CNT;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_FIX;
        end
      end

      // Reduce the entry at pos by the remaining amount
      S_FIX: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IDX_W-1:0];
        mem_wdata = '{delta: sub[15:0], tag: rd_q.tag};
        if (cmd_r == CMD_INSERT) begin
          k_nxt     = count_r;
          state_nxt = S_SHR_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Move entries from pos up by one, top first
      S_SHR_RD: begin
        if (k_r > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = km1[IDX_W-1:0];
          state_nxt = S_SHR_WR;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_SHR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        mem_wdata = rd_q;
        k_nxt     = km1;
        state_nxt = S_SHR_RD;
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IDX_W-1:0];
        mem_wdata = '{delta: acc_r, tag: tag_r};
        count_nxt = count_r + ONE_CNT;
        state_nxt = S_DONE;
      end

      // Time passed: zero covered entries, reduce the first one not covered
      S_TP_RD: begin
        if (pos_r == count_r) begin
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_r[IDX_W-1:0];
          state_nxt = S_TP_CMP;
        end
      end

      S_TP_CMP: begin
        if (!sub[16] && (sub[15:0] != 16'd0)) begin
          acc_nxt   = sub[15:0];
          mem_we    = 1'b1;
          mem_waddr = pos_r[IDX_W-1:0];
          mem_wdata = '{delta: 16'd0, tag: rd_q.tag};
          pos_nxt   = pos_r + ONE_CNT;
          state_nxt = S_TP_RD;
        end else begin
          state_nxt = S_FIX;
        end
      end

      // Pop: check head; if it has expired, move the rest down by one
      S_POP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_POP_CHK;
      end

      S_POP_CHK: begin
        if (rd_q.delta == 16'd0) begin
          popped_nxt = rd_q.tag;
          status_nxt = ST_POPPED;
          k_nxt      = ONE_CNT;
          state_nxt  = S_SHL_RD;
        end else begin
          status_nxt = ST_NONE;
          state_nxt  = S_DONE;
        end
      end

      S_SHL_RD: begin
        if (k_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = k_r[IDX_W-1:0];
          state_nxt = S_SHL_WR;
        end else begin
          count_nxt = count_r - ONE_CNT;
          state_nxt = S_DONE;
        end
      end

      S_SHL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = km1[IDX_W-1:0];
        mem_wdata = rd_q;
        k_nxt     = k_r + ONE_CNT;
        state_nxt = S_SHL_RD;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.popped_tag  = popped_r;
          out_data_nxt.entry_count = 5'(count_r);
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    acc_r      <= acc_nxt;
    tag_r      <= tag_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    status_r   <= status_nxt;
    popped_r   <= popped_nxt;
    out_data_r <= out_data_nxt;
  end

  // Entry count stays within the queue depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  // A command transfer makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after command transfer");

  // A refused insert is loaded into the result only with a full queue
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_ready) && status_r == ST_FULL |->
      count_r == CAP_CNT)
    else $error("full status with room left");

  // A pop result raising out_valid carries the tag held when it was loaded; the count is unchanged
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_data.status == ST_POPPED |->
      count_r == $past(count_r) && out_data.popped_tag == $past(popped_r))
    else $error("pop result inconsistent");

endmodule

// ----- tb/tb_delta_list_timer_queue.sv -----
`timescale 1ns / 100ps

module tb_delta_list_timer_queue;
  import dltq_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int ITEMS      = 1700;
  localparam int TAIL_ITEMS = 150;   // last stretch runs with no random idling
  localparam int LONG_HOLD  = 200;   // one long receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 60;    // settle time after the last result, in cycles

  // Unused command code; the block answers it with a done result and leaves the queue unchanged
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct {
    dltq_in_t cmd;
    bit       drain;   // hold this command until every result is back
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  dltq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  dltq_out_t out_data;

  pending_t  pending[$];
  dltq_out_t timer_results[$];
  int        total_items = 0;
  int        accepted_items = 0;
  int        mismatches = 0;
  int        cycle_cnt = 0;
  bit        in_taken = 1'b0;
  int        send_gap = 0;
  int        recv_hold = 0;
  bit        long_hold_done = 1'b0;

  // Shadow copy of the timer queue
  logic [15:0] shadow_delta [CAP];
  logic [7:0]  shadow_tag   [CAP];
  int          shadow_count = 0;

  delta_list_timer_queue #(.CAPACITY(CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt++;

  // Apply one command to the shadow queue and return the result it should give
  function automatic dltq_out_t apply_timer_cmd(dltq_in_t c);
    dltq_out_t   r;
    int          pos;
    int          k;
    bit          stop;
    logic [15:0] rest;
    r = '0;
    rest = c.time_value;
    case (c.command)
      CMD_INSERT: begin
        if (shadow_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // pass every entry expiring at or before the new one
          pos = 0;
          while (pos < shadow_count && shadow_delta[pos] <= rest) begin
            rest -= shadow_delta[pos];
            pos++;
          end
          if (pos < shadow_count) shadow_delta[pos] -= rest;
          for (k = shadow_count; k > pos; k--) begin
            shadow_delta[k] = shadow_delta[k-1];
            shadow_tag[k]   = shadow_tag[k-1];
          end
          shadow_delta[pos] = rest;
          shadow_tag[pos]   = c.entry_tag;
          shadow_count++;
          r.status = ST_DONE;
        end
      end
      CMD_TIME: begin
        // covered entries go to zero, first remainder is reduced
        stop = (rest == 16'd0);
        for (k = 0; k < shadow_count && !stop; k++) begin
          if (shadow_delta[k] < rest) begin
            rest -= shadow_delta[k];
            shadow_delta[k] = 16'd0;
          end else begin
            shadow_delta[k] -= rest;
            stop = 1'b1;
          end
        end
        r.status = ST_DONE;
      end
      CMD_POP: begin
        if (shadow_count > 0 && shadow_delta[0] == 16'd0) begin
          r.popped_tag = shadow_tag[0];
          for (k = 1; k < shadow_count; k++) begin
            shadow_delta[k-1] = shadow_delta[k];
            shadow_tag[k-1]   = shadow_tag[k];
          end
          shadow_count--;
          r.status = ST_POPPED;
        end else begin
          r.status = ST_NONE;
        end
      end
      default: r.status = ST_DONE;
    endcase
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $time);
    mismatches++;
  endtask

  task automatic add_cmd(input logic [1:0] cmd, input logic [15:0] tv,
                         input logic [7:0] tag, input bit drain);
    pending_t p;
    p.cmd.command    = cmd;
    p.cmd.time_value = tv;
    p.cmd.entry_tag  = tag;
    p.drain          = drain;
    pending.push_back(p);
  endtask

  // Driver: presents commands at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].drain && timer_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending.size() > TAIL_ITEMS && ((cycle_cnt >> 9) & 3) != 3 &&
                   $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending[0].cmd;
        in_valid <= 1'b1;
        void'(pending.pop_front());
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && accepted_items >= 400) begin
      long_hold_done = 1'b1;
      recv_hold = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (pending.size() > TAIL_ITEMS && ((cycle_cnt >> 9) & 3) != 2 &&
                 $urandom_range(0, 7) == 0) begin
      recv_hold = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: record accepted commands, check each result transfer
  always @(posedge clk) begin : result_check
    dltq_out_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      timer_results.push_back(apply_timer_cmd(in_data));
      accepted_items++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (timer_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_data.status), -1);
      end else begin
        want = timer_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.popped_tag !== want.popped_tag)
          report_mismatch("popped_tag", int'(out_data.popped_tag),
                          int'(want.popped_tag));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", int'(out_data.entry_count),
                          int'(want.entry_count));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int          mode;
    int          len;
    int          pick;
    int          sel;
    int          ins_p;
    int          tim_p;
    int          pop_p;
    bit          first;
    logic [15:0] tv;

    // directed: empty queue cases and the unused command
    add_cmd(CMD_POP, 16'd0, 8'd0, 1'b0);
    add_cmd(CMD_TIME, 16'd0, 8'd0, 1'b0);
    add_cmd(CMD_TIME, 16'd100, 8'd0, 1'b0);
    add_cmd(CMD_NOP, 16'hFFFF, 8'hFF, 1'b0);
    // fill the queue: delay extremes and an equal expiry pair
    add_cmd(CMD_INSERT, 16'd0, 8'h00, 1'b0);
    add_cmd(CMD_INSERT, 16'hFFFF, 8'hFF, 1'b0);
    add_cmd(CMD_INSERT, 16'd100, 8'h55, 1'b0);
    add_cmd(CMD_INSERT, 16'd100, 8'hAA, 1'b0);
    add_cmd(CMD_INSERT, 16'd40, 8'h11, 1'b0);
    repeat (CAP - 5)
      add_cmd(CMD_INSERT, 16'($urandom_range(1, 300)), 8'($urandom_range(0, 255)), 1'b0);
    // full queue refuses the insert
    add_cmd(CMD_INSERT, 16'd7, 8'h77, 1'b0);
    // expired head pops, then a head still waiting
    add_cmd(CMD_POP, 16'd0, 8'd0, 1'b0);
    add_cmd(CMD_POP, 16'd0, 8'd0, 1'b0);
    add_cmd(CMD_TIME, 16'd0, 8'd0, 1'b0);
    add_cmd(CMD_TIME, 16'd40, 8'd0, 1'b0);
    add_cmd(CMD_POP, 16'd0, 8'd0, 1'b0);
    // elapsed time beyond the whole queue
    add_cmd(CMD_TIME, 16'hFFFF, 8'd0, 1'b0);
    add_cmd(CMD_POP, 16'd0, 8'd0, 1'b0);

    // random phases, each leaning toward filling, draining or a mix
    first = 1'b1;
    while (pending.size() < ITEMS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(30, 90);
      case (mode)
        0:       begin ins_p = 65; tim_p = 15; pop_p = 16; end
        1:       begin ins_p = 15; tim_p = 35; pop_p = 46; end
        default: begin ins_p = 40; tim_p = 25; pop_p = 31; end
      endcase
      repeat (len) begin
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (pick < ins_p) begin
          if (sel < 5)      tv = 16'($urandom_range(0, 20));
          else if (sel < 7) tv = 16'(10 * $urandom_range(0, 10));
          else if (sel < 9) tv = 16'($urandom_range(0, 1000));
          else              tv = 16'($urandom_range(0, 65535));
          add_cmd(CMD_INSERT, tv, 8'($urandom_range(0, 255)), first);
        end else if (pick < ins_p + tim_p) begin
          if (sel == 0)     tv = 16'd0;
          else if (sel < 6) tv = 16'($urandom_range(1, 30));
          else if (sel < 8) tv = 16'($urandom_range(0, 500));
          else if (sel < 9) tv = 16'($urandom_range(0, 65535));
          else              tv = 16'hFFFF;
          add_cmd(CMD_TIME, tv, 8'($urandom_range(0, 255)), first);
        end else if (pick < ins_p + tim_p + pop_p) begin
          add_cmd(CMD_POP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), first);
        end else begin
          add_cmd(CMD_NOP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), first);
        end
        // the first random command and a few others wait for a drained pipe
        first = ($urandom_range(0, 199) == 0);
      end
    end
    total_items = pending.size();

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (accepted_items == total_items);
    wait (timer_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("delta_list_timer_queue regression: pass");
    end else begin
      $display("delta_list_timer_queue regression: fail");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("delta_list_timer_queue regression: fail");
    $finish;
  end

endmodule
